>>> hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU cache table
// Entry count, field widths, commands and register map.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned Entries   = 16;
  localparam int unsigned IdxBits   = $clog2(Entries);
  localparam int unsigned CountBits = 16;
  localparam int unsigned OccBits   = $clog2(Entries + 1);
  localparam int unsigned CapBits   = 5;
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned ValBits   = 32;
  localparam int unsigned AddrBits  = 3;

  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [CapBits-1:0]   CapReset = CapBits'(Entries);
  localparam logic [AddrBits-1:0]  RegCapacity = '0;

  typedef enum logic {
    CmdGet = 1'b0,
    CmdPut = 1'b1
  } cmd_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic scan_clr;   // start a new scan
    logic scan_en;    // examine entry at scan index
    logic [IdxBits-1:0] scan_idx;
    logic do_evict;   // remove the chosen victim
    logic do_touch;   // hit update
    logic do_insert;  // insert new key into free slot
    logic load_item;  // capture the request
  } dp_cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic hit;
    logic has_free;
    logic has_victim;
    logic full;       // occupancy reached capacity
    logic cap_zero;
    cmd_e cmd;
  } dp_stat_t;

endpackage

>>> hdl/lfu_if.sv
// ----------------------------------------------------------------------------
// lfu_req_if / lfu_rsp_if: valid/ready channels of the LFU cache table
// Request carries command, key and value; response carries the result.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  import lfu_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [KeyBits-1:0] key;
  logic [ValBits-1:0] value;
  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [ValBits-1:0] read_value;
  logic               evicted;
  logic [KeyBits-1:0] evicted_key;
  modport source (output valid, found, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

>>> hdl/lfu_datapath.sv
// ----------------------------------------------------------------------------
// lfu_datapath: entry storage, scan registers and update logic
// Scans one entry a cycle for key match, free slot and LFU/LRU victim.
// ----------------------------------------------------------------------------
module lfu_datapath import lfu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [CapBits-1:0]   cap_i,
  input  logic                 in_cmd_i,
  input  logic [KeyBits-1:0]   in_key_i,
  input  logic [ValBits-1:0]   in_val_i,
  output dp_stat_t             stat_o,
  output logic                 found_o,
  output logic [ValBits-1:0]   read_value_o,
  output logic                 evicted_o,
  output logic [KeyBits-1:0]   evicted_key_o
);

  logic [Entries-1:0]   valid_q;
  logic [KeyBits-1:0]   key_q   [Entries];
  logic [ValBits-1:0]   val_q   [Entries];
  logic [CountBits-1:0] cnt_q   [Entries];
  logic [IdxBits-1:0]   rank_q  [Entries];
  logic [OccBits-1:0]   occ_q;

  // captured request
  cmd_e               cmd_q;
  logic [KeyBits-1:0] ikey_q;
  logic [ValBits-1:0] ival_q;

  // scan results
  logic               hit_q, free_q, vic_q;
  logic [IdxBits-1:0] hit_idx_q, free_idx_q, vic_idx_q;

  logic [IdxBits-1:0]   si;
  logic [KeyBits-1:0]   s_key;
  logic [CountBits-1:0] s_cnt, v_cnt;
  logic [IdxBits-1:0]   s_rank, v_rank;
  logic                 better;
  logic [OccBits-1:0]   cap_eff;

  assign si     = cmd_i.scan_idx;
  assign s_key  = key_q[si];
  assign s_cnt  = cnt_q[si];
  assign s_rank = rank_q[si];
  assign v_cnt  = cnt_q[vic_idx_q];
  assign v_rank = rank_q[vic_idx_q];
  assign better = !vic_q || (s_cnt < v_cnt) || (s_cnt == v_cnt && s_rank > v_rank);
  assign cap_eff = (cap_i > CapBits'(Entries)) ? OccBits'(Entries) : OccBits'(cap_i);

  // scan and request registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      free_q <= 1'b0;
      vic_q <= 1'b0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
      vic_idx_q <= '0;
    end else if (cmd_i.scan_clr) begin
      hit_q <= 1'b0;
      free_q <= 1'b0;
      vic_q <= 1'b0;
    end else if (cmd_i.scan_en) begin
      if (valid_q[si]) begin
        if (s_key == ikey_q && !hit_q) begin
          hit_q <= 1'b1;
          hit_idx_q <= si;
        end
        if (better) begin
          vic_q <= 1'b1;
          vic_idx_q <= si;
        end
      end else if (!free_q) begin
        free_q <= 1'b1;
        free_idx_q <= si;
      end
    end else if (cmd_i.do_evict) begin
      // victim slot becomes the lowest-numbered free slot if it is lower
      free_q <= 1'b1;
      if (!free_q || vic_idx_q < free_idx_q) free_idx_q <= vic_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q  <= cmd_e'(in_cmd_i);
      ikey_q <= in_key_i;
      ival_q <= in_val_i;
    end
  end

  // entry updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if (cmd_i.do_evict) begin
      valid_q[vic_idx_q] <= 1'b0;
      occ_q <= occ_q - OccBits'(1);
    end else if (cmd_i.do_insert) begin
      valid_q[free_idx_q] <= 1'b1;
      occ_q <= occ_q + OccBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Entries; i++) begin
      if (cmd_i.do_evict) begin
        if (valid_q[i] && rank_q[i] > v_rank) rank_q[i] <= rank_q[i] - IdxBits'(1);
      end else if (cmd_i.do_touch) begin
        if (IdxBits'(i) == hit_idx_q) begin
          rank_q[i] <= '0;
          if (cnt_q[i] != CountMax) cnt_q[i] <= cnt_q[i] + CountBits'(1);
          if (cmd_q == CmdPut) val_q[i] <= ival_q;
        end else if (valid_q[i] && rank_q[i] < rank_q[hit_idx_q]) begin
          rank_q[i] <= rank_q[i] + IdxBits'(1);
        end
      end else if (cmd_i.do_insert) begin
        if (IdxBits'(i) == free_idx_q) begin
          rank_q[i] <= '0;
          cnt_q[i]  <= CountBits'(1);
          key_q[i]  <= ikey_q;
          val_q[i]  <= ival_q;
        end else if (valid_q[i]) begin
          rank_q[i] <= rank_q[i] + IdxBits'(1);
        end
      end
    end
  end

  // result fields, valid once the scan is done
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      evicted_o <= 1'b0;
      evicted_key_o <= '0;
    end else if (cmd_i.do_evict) begin
      evicted_o <= 1'b1;
      evicted_key_o <= key_q[vic_idx_q];
    end
  end

  always_comb begin
    found_o = 1'b0;
    read_value_o = '0;
    if (cmd_q == CmdGet) begin
      found_o = hit_q;
      read_value_o = hit_q ? val_q[hit_idx_q] : '1;
    end else if (cap_i != '0) begin
      found_o = hit_q;
    end
  end

  assign stat_o.hit        = hit_q;
  assign stat_o.has_free   = free_q;
  assign stat_o.has_victim = vic_q;
  assign stat_o.full       = (occ_q >= cap_eff);
  assign stat_o.cap_zero   = (cap_i == '0);
  assign stat_o.cmd        = cmd_q;

  // occupancy never exceeds the entry count
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= OccBits'(Entries))
    else $error("occupancy overflow");
  // occupancy tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy mismatch");
  // evict and insert never in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.do_evict && cmd_i.do_insert))
    else $error("evict and insert overlap");

endmodule

>>> hdl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl: sequencer for one request of the LFU cache table
// Accept, scan all entries, update, then hold the response.
// ----------------------------------------------------------------------------
module lfu_ctrl import lfu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StScan, StDecide, StInsert, StRsp
  } state_e;

  state_e state_q;
  logic [IdxBits-1:0] idx_q;
  logic in_fire;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o = '0;
    cmd_o.scan_idx  = idx_q;
    cmd_o.load_item = in_fire;
    cmd_o.scan_clr  = in_fire;
    cmd_o.scan_en   = (state_q == StScan);
    if (state_q == StDecide) begin
      // a put with zero capacity leaves the store untouched, hit or not
      if (stat_i.hit && !(stat_i.cmd == CmdPut && stat_i.cap_zero)) begin
        cmd_o.do_touch = 1'b1;
      end else if (!stat_i.hit && stat_i.cmd == CmdPut && !stat_i.cap_zero
                   && stat_i.full && stat_i.has_victim) begin
        cmd_o.do_evict = 1'b1;
      end
    end
    if (state_q == StInsert) cmd_o.do_insert = stat_i.has_free;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          idx_q <= '0;
          if (in_fire) state_q <= StScan;
        end
        StScan: begin
          idx_q <= idx_q + IdxBits'(1);
          if (idx_q == IdxBits'(Entries - 1)) state_q <= StDecide;
        end
        StDecide: begin
          if (!stat_i.hit && stat_i.cmd == CmdPut && !stat_i.cap_zero) begin
            state_q <= StInsert;
          end else begin
            state_q <= StRsp;
            out_valid_o <= 1'b1;
          end
        end
        StInsert: begin
          state_q <= StRsp;
          out_valid_o <= 1'b1;
        end
        StRsp: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("accept during response");
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> state_q == StScan)
    else $error("scan did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_insert |-> stat_i.cmd == CmdPut)
    else $error("insert on get");

endmodule

>>> hdl/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table: LFU key/value store with LRU tiebreak
// Fully associative, 16 entries, APB capacity register.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// req      in   command, key, value
// rsp      out  found, read_value, evicted, evicted_key
// apb      in   capacity at byte address 0
//
// One request at a time: accept, 16-entry scan, update, plus an insert step for
// a put of a new key.
// Response is held until taken; the next request is accepted the cycle after.
// Reset clears valid bits and occupancy; capacity resets to 16.
module lfu_cache_table import lfu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lfu_req_if.sink             req,
  lfu_rsp_if.source           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [CapBits-1:0] cap_q;
  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  // capacity register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapReset;
    else if (psel && penable && pwrite && paddr == RegCapacity) cap_q <= pwdata[CapBits-1:0];
  end
  assign prdata = (paddr == RegCapacity) ? {{(32-CapBits){1'b0}}, cap_q} : '0;

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .stat_i     (dstat),
    .cmd_o      (dcmd)
  );

  lfu_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (dcmd),
    .cap_i        (cap_q),
    .in_cmd_i     (req.command),
    .in_key_i     (req.key),
    .in_val_i     (req.value),
    .stat_o       (dstat),
    .found_o      (rsp.found),
    .read_value_o (rsp.read_value),
    .evicted_o    (rsp.evicted),
    .evicted_key_o(rsp.evicted_key)
  );

endmodule

>>> tb/tb_lfu_cache_table.sv
// ----------------------------------------------------------------------------
// tb_lfu_cache_table: self-checking bench for the LFU cache table
// Drives get/put requests with random gaps and response stalls, writes the
// capacity register between phases, and compares every response with a
// behavioral LFU/LRU predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lfu_cache_table;
  import lfu_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic               found;
    logic [ValBits-1:0] read_value;
    logic               evicted;
    logic [KeyBits-1:0] evicted_key;
  } lfu_rsp_t;

  typedef struct {
    cmd_e               cmd;
    logic [KeyBits-1:0] key;
    logic [ValBits-1:0] value;
    logic               chk;    // typed-in result present
    lfu_rsp_t           rsp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lfu_req_if req_if ();
  lfu_rsp_if rsp_if ();

  lfu_cache_table DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req     (req_if.sink),
    .rsp     (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state
  logic [CapBits-1:0]   cap_q;
  logic                 slot_vld [Entries];
  logic [KeyBits-1:0]   slot_key [Entries];
  logic [ValBits-1:0]   slot_val [Entries];
  logic [CountBits-1:0] slot_cnt [Entries];
  int unsigned          slot_age [Entries];
  int unsigned          fill;

  lfu_rsp_t pending_rsps[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, exp);
    errors++;
  endtask

  // Move slot s to most recent, bump its count (saturating)
  function automatic void promote(input int s);
    for (int i = 0; i < Entries; i++)
      if (slot_vld[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
    if (slot_cnt[s] != CountMax) slot_cnt[s]++;
  endfunction

  function automatic lfu_rsp_t lfu_access(input cmd_e cmd, input logic [KeyBits-1:0] k,
                                          input logic [ValBits-1:0] v);
    lfu_rsp_t r;
    int hit_slot, vic, free_slot;
    int unsigned cap_eff;
    r = '0;
    hit_slot = -1;
    vic = -1;
    free_slot = -1;
    cap_eff = (cap_q > Entries) ? Entries : cap_q;
    for (int i = 0; i < Entries; i++)
      if (hit_slot < 0 && slot_vld[i] && slot_key[i] == k) hit_slot = i;
    if (cmd == CmdGet) begin
      if (hit_slot >= 0) begin
        r.found = 1'b1;
        r.read_value = slot_val[hit_slot];
        promote(hit_slot);
      end else begin
        r.read_value = '1;
      end
    end else if (cap_eff != 0) begin
      if (hit_slot >= 0) begin
        r.found = 1'b1;
        slot_val[hit_slot] = v;
        promote(hit_slot);
      end else begin
        if (fill >= cap_eff) begin
          for (int i = 0; i < Entries; i++)
            if (slot_vld[i] && (vic < 0 || slot_cnt[i] < slot_cnt[vic] ||
                (slot_cnt[i] == slot_cnt[vic] && slot_age[i] > slot_age[vic])))
              vic = i;
          if (vic >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = slot_key[vic];
            slot_vld[vic] = 1'b0;
            for (int i = 0; i < Entries; i++)
              if (slot_vld[i] && slot_age[i] > slot_age[vic]) slot_age[i]--;
            fill--;
          end
        end
        for (int i = Entries - 1; i >= 0; i--)
          if (!slot_vld[i]) free_slot = i;
        if (free_slot >= 0) begin
          for (int i = 0; i < Entries; i++)
            if (slot_vld[i]) slot_age[i]++;
          slot_vld[free_slot] = 1'b1;
          slot_key[free_slot] = k;
          slot_val[free_slot] = v;
          slot_cnt[free_slot] = 1;
          slot_age[free_slot] = 0;
          fill++;
        end
      end
    end
    return r;
  endfunction

  // Response side: random stalls and checking
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        if (pending_rsps.size() == 0) begin
          report("unexpected response", 32'h0, 32'h0);
        end else begin
          lfu_rsp_t e;
          e = pending_rsps.pop_front();
          if (rsp_if.found !== e.found) report("found", rsp_if.found, e.found);
          if (rsp_if.read_value !== e.read_value)
            report("read_value", rsp_if.read_value, e.read_value);
          if (rsp_if.evicted !== e.evicted) report("evicted", rsp_if.evicted, e.evicted);
          if (rsp_if.evicted_key !== e.evicted_key)
            report("evicted_key", rsp_if.evicted_key, e.evicted_key);
        end
      end
      rsp_if.ready <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  // Watchdog: cycles with no request or response taken and no APB select
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_capacity(input logic [CapBits-1:0] c);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegCapacity; pwdata <= 32'(c);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cap_q = c;
  endtask

  task automatic wait_drained();
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Send one request; idle gaps before it at random unless no_idle is set
  task automatic send(input cmd_e cmd, input logic [KeyBits-1:0] k,
                      input logic [ValBits-1:0] v, output lfu_rsp_t exp);
    while (!no_idle && $urandom_range(99) < 38) @(posedge clk);
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.key <= k;
    req_if.value <= v;
    do @(posedge clk); while (!req_if.ready);
    exp = lfu_access(cmd, k, v);
    pending_rsps.push_back(exp);
    req_if.valid <= 1'b0;
    // block is busy scanning after the accept, so this costs no throughput
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key(input int unsigned pool);
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return 32'h8000_0000 + $urandom_range(3);
      2:       return 32'h7fff_fffc + $urandom_range(3);
      default: return 32'($urandom_range(pool));
    endcase
  endfunction

  stim_row_t dir_rows[$];
  logic [CapBits-1:0] cap_plan[] = '{5'd16, 5'd4, 5'd0, 5'd1, 5'd31, 5'd9, 5'd16};

  initial begin
    lfu_rsp_t exp;
    stim_row_t row;
    cmd_e c;
    int unsigned pool;
    req_if.valid = 1'b0;
    req_if.command = CmdGet;
    req_if.key = '0;
    req_if.value = '0;
    cap_q = CapReset;
    fill = 0;
    foreach (slot_vld[i]) begin
      slot_vld[i] = 1'b0; slot_key[i] = '0; slot_val[i] = '0;
      slot_cnt[i] = '0; slot_age[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: miss after reset, key extremes, hit, update, count at max untested
    dir_rows = '{
      '{CmdGet, 32'h0000_0000, 32'h0,         1'b1, '{1'b0, 32'hffff_ffff, 1'b0, 32'h0}},
      '{CmdPut, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{CmdPut, 32'h7fff_ffff, 32'h8000_0000, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{CmdGet, 32'h8000_0000, 32'h0,         1'b1, '{1'b1, 32'h7fff_ffff, 1'b0, 32'h0}},
      '{CmdGet, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
      '{CmdPut, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{CmdPut, 32'h8000_0000, 32'h1234_5678, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
      '{CmdGet, 32'h0000_0001, 32'h0,         1'b1, '{1'b0, 32'hffff_ffff, 1'b0, 32'h0}}
    };
    // Fill past 16 entries so the oldest single-use keys are evicted
    for (int i = 0; i < 15; i++) begin
      row.cmd = CmdPut; row.key = 32'(100 + i); row.value = $urandom(); row.chk = 1'b0;
      row.rsp = '0;
      dir_rows.push_back(row);
    end
    foreach (dir_rows[i]) begin
      send(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].value, exp);
      if (dir_rows[i].chk && exp !== dir_rows[i].rsp)
        report("directed row", 32'(i), 32'h0);
    end

    // Random phases over several capacities; first one runs without gaps
    foreach (cap_plan[p]) begin
      wait_drained();
      write_capacity(cap_plan[p]);
      no_idle = (p == 0);
      pool = (p % 2) ? 6 : 40;
      for (int n = 0; n < 95; n++) begin
        c = ($urandom_range(99) < 55) ? CmdPut : CmdGet;
        send(c, pick_key(pool), $urandom(), exp);
        if (n == 50) wait_drained();
      end
      no_idle = 1'b0;
    end

    wait_drained();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
